// File: rtl/cbd_pkg.sv
package cbd_pkg;

	localparam int DEPTH     = 128;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OFF_W     = 7;
	localparam int CMP_W     = (CNT_W > OFF_W) ? CNT_W : OFF_W;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_READ_FRONT = 3'd4;
	localparam logic [2:0] MODE_READ_BACK  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] push_value;
		logic [OFF_W-1:0]   read_offset;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic [7:0]         entries_held;
		logic               is_empty;
		logic               is_full;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic execute;
		logic load_out;
	} cbd_cmd_t;

endpackage

// File: rtl/cbd_ctrl.sv
module cbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cbd_pkg::cbd_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FORM
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free      = !out_valid_q || out_ready;
	assign cmd.load_item = in_valid && in_ready_q;
	assign cmd.execute   = (state_q == S_EXEC);
	assign cmd.load_out  = (state_q == S_FORM) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if ((state_q == S_FORM) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FORM;
				end
				S_FORM: begin
					if (out_free) begin
						in_ready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

// File: rtl/cbd_dpath.sv
module cbd_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  cbd_pkg::cbd_cmd_t  cmd,
	input  cbd_pkg::in_item_t  in_item,
	output cbd_pkg::out_item_t out_item
);

	localparam logic [cbd_pkg::IDX_W-1:0] LAST_IDX = cbd_pkg::IDX_W'(cbd_pkg::DEPTH - 1);
	localparam logic [cbd_pkg::IDX_W:0]   DEPTH_X  = (cbd_pkg::IDX_W + 1)'(cbd_pkg::DEPTH);
	localparam logic [cbd_pkg::CNT_W-1:0] FULL_CNT = cbd_pkg::CNT_W'(cbd_pkg::DEPTH);

	cbd_pkg::in_item_t  item_q;
	cbd_pkg::out_item_t out_q;

	logic [cbd_pkg::IDX_W-1:0]     head_q, tail_q;
	logic [cbd_pkg::CNT_W-1:0]     count_q;
	logic [cbd_pkg::DATA_BITS-1:0] mem [cbd_pkg::DEPTH];
	logic [cbd_pkg::DATA_BITS-1:0] rd_data_s2;
	logic [1:0]                    status_s2;
	logic                          want_s2;

	logic [cbd_pkg::IDX_W-1:0]     head_up, head_dn, tail_up, tail_dn;
	logic [cbd_pkg::IDX_W:0]       fwd_sum, bwd_sum;
	logic [cbd_pkg::IDX_W-1:0]     fwd_idx, bwd_idx;
	logic                          empty, full, in_range;
	logic [cbd_pkg::DATA_BITS-1:0] wdata;

	logic [1:0]                    status_d;
	logic [cbd_pkg::IDX_W-1:0]     addr, head_d, tail_d;
	logic [cbd_pkg::CNT_W-1:0]     count_d;
	logic                          we, re;

	logic signed [cbd_pkg::DATA_BITS-1:0] rd_signed;
	logic signed [31:0]                   rd_wide;

	assign head_up = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dn = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_up = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dn = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	// offset is below count when used, so one subtract brings both sums in range
	assign fwd_sum = {1'b0, head_q} + (cbd_pkg::IDX_W + 1)'(item_q.read_offset);
	assign bwd_sum = {1'b0, tail_q} + DEPTH_X - (cbd_pkg::IDX_W + 1)'(item_q.read_offset);
	assign fwd_idx = (fwd_sum >= DEPTH_X) ? cbd_pkg::IDX_W'(fwd_sum - DEPTH_X)
	                                      : cbd_pkg::IDX_W'(fwd_sum);
	assign bwd_idx = (bwd_sum >= DEPTH_X) ? cbd_pkg::IDX_W'(bwd_sum - DEPTH_X)
	                                      : cbd_pkg::IDX_W'(bwd_sum);

	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_CNT);
	assign in_range = cbd_pkg::CMP_W'(item_q.read_offset) < cbd_pkg::CMP_W'(count_q);
	assign wdata    = cbd_pkg::DATA_BITS'($unsigned(item_q.push_value));

	always_comb begin
		status_d = cbd_pkg::ST_OK;
		addr     = head_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		we       = 1'b0;
		re       = 1'b0;
		unique case (item_q.mode)
			cbd_pkg::MODE_PUSH_FRONT, cbd_pkg::MODE_PUSH_BACK: begin
				if (full) begin
					status_d = cbd_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
					if (empty) begin
						addr   = '0;
						head_d = '0;
						tail_d = '0;
					end else if (item_q.mode == cbd_pkg::MODE_PUSH_FRONT) begin
						addr   = head_dn;
						head_d = head_dn;
					end else begin
						addr   = tail_up;
						tail_d = tail_up;
					end
				end
			end
			cbd_pkg::MODE_POP_FRONT, cbd_pkg::MODE_POP_BACK: begin
				if (empty) begin
					status_d = cbd_pkg::ST_EMPTY;
				end else begin
					re      = 1'b1;
					count_d = count_q - 1'b1;
					if (item_q.mode == cbd_pkg::MODE_POP_FRONT) begin
						addr = head_q;
						if (count_q != cbd_pkg::CNT_W'(1))
							head_d = head_up;
					end else begin
						addr = tail_q;
						if (count_q != cbd_pkg::CNT_W'(1))
							tail_d = tail_dn;
					end
				end
			end
			cbd_pkg::MODE_READ_FRONT, cbd_pkg::MODE_READ_BACK: begin
				if (!in_range) begin
					status_d = cbd_pkg::ST_RANGE;
				end else begin
					re   = 1'b1;
					addr = (item_q.mode == cbd_pkg::MODE_READ_FRONT) ? fwd_idx : bwd_idx;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			status_s2 <= cbd_pkg::ST_OK;
			want_s2   <= 1'b0;
		end else if (cmd.execute) begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			status_s2 <= status_d;
			want_s2   <= re;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (we)
				mem[addr] <= wdata;
			if (re)
				rd_data_s2 <= mem[addr];
		end
	end

	assign rd_signed = rd_data_s2;
	assign rd_wide   = 32'(rd_signed);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status       <= status_s2;
			out_q.data_out     <= want_s2 ? rd_wide : '0;
			out_q.entries_held <= 8'(count_q);
			out_q.is_empty     <= (count_q == '0);
			out_q.is_full      <= (count_q == FULL_CNT);
		end
	end

	assign out_item = out_q;

endmodule

// File: rtl/circular_buffer_deque.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | in_item  (mode, push_value, read_offset)
// out      | out_valid / out_ready| out_item (status, data_out, entries_held,
//          |                      |           is_empty, is_full)
//
// Each item passes through three steps: capture, store access, result formation.
// The single store port (one write or one registered read per item) sets that.
// arst_n clears pointers, count and handshake state; store contents stay unknown.
// A stalled result is held in the output register; the next item may be
// accepted while it waits, and is itself held back only in its final cycle.
module circular_buffer_deque (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cbd_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cbd_pkg::out_item_t out_item
);

	cbd_pkg::cbd_cmd_t cmd;

	// sequencing: accept, execute, form result
	cbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// pointers, count, slot store and result register
	cbd_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.out_item (out_item)
	);

`ifndef SYNTHESIS
	// a rejected or out-of-range item never returns data
	a_reject_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status != cbd_pkg::ST_OK) |-> (out_item.data_out == '0))
		else $error("rejected item carries data");

	// one item in flight: intake closes after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while busy");

	// flags never contradict
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.is_empty && out_item.is_full))
		else $error("empty and full together");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	// modes 6 and 7 are spare codes: the deque treats them as no-ops
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 1526;
	localparam int HOLD_AT      = 700;  // items accepted before the long output hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;

	// trends for the random part
	localparam int TREND_FILL  = 0;
	localparam int TREND_DRAIN = 1;
	localparam int TREND_CHURN = 2;

	// receiver stall styles
	localparam int RX_OPEN     = 0;
	localparam int RX_COIN     = 1;
	localparam int RX_EVERY4TH = 2;
	localparam int RX_SPARSE   = 3;

	// Shadow deque: mirrors the slot store, both indices and the count, and keeps
	// the results owed by the block in order of acceptance.
	class deque_tracker;
		logic [31:0] slots [cbd_pkg::DEPTH];
		int unsigned front_idx;
		int unsigned back_idx;
		int unsigned held;
		cbd_pkg::out_item_t owed[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned status_tally [4];
		int unsigned peak_held;
		int unsigned full_hits;

		function new();
			front_idx = 0;
			back_idx = 0;
			held = 0;
			mismatches = 0;
			checked = 0;
			peak_held = 0;
			full_hits = 0;
			foreach (status_tally[i])
				status_tally[i] = 0;
		endfunction

		function void note_accepted(cbd_pkg::in_item_t it);
			cbd_pkg::out_item_t r;
			int unsigned idx;
			r = '0;
			case (it.mode)
			cbd_pkg::MODE_PUSH_FRONT, cbd_pkg::MODE_PUSH_BACK: begin
				if (held == cbd_pkg::DEPTH) begin
					r.status = cbd_pkg::ST_FULL;
				end else begin
					// a push into an empty deque restarts both ends at slot 0
					if (held == 0) begin
						front_idx = 0;
						back_idx = 0;
						idx = 0;
					end else if (it.mode == cbd_pkg::MODE_PUSH_FRONT) begin
						front_idx = (front_idx + cbd_pkg::DEPTH - 1) % cbd_pkg::DEPTH;
						idx = front_idx;
					end else begin
						back_idx = (back_idx + 1) % cbd_pkg::DEPTH;
						idx = back_idx;
					end
					slots[idx] = it.push_value;
					held++;
					if (held == cbd_pkg::DEPTH)
						full_hits++;
				end
			end
			cbd_pkg::MODE_POP_FRONT, cbd_pkg::MODE_POP_BACK: begin
				if (held == 0) begin
					r.status = cbd_pkg::ST_EMPTY;
				end else begin
					// popping the last entry leaves the indices where they are
					if (it.mode == cbd_pkg::MODE_POP_FRONT) begin
						r.data_out = slots[front_idx];
						if (held > 1)
							front_idx = (front_idx + 1) % cbd_pkg::DEPTH;
					end else begin
						r.data_out = slots[back_idx];
						if (held > 1)
							back_idx = (back_idx + cbd_pkg::DEPTH - 1) % cbd_pkg::DEPTH;
					end
					held--;
				end
			end
			cbd_pkg::MODE_READ_FRONT, cbd_pkg::MODE_READ_BACK: begin
				if (it.read_offset >= held) begin
					r.status = cbd_pkg::ST_RANGE;
				end else begin
					if (it.mode == cbd_pkg::MODE_READ_FRONT)
						idx = (front_idx + it.read_offset) % cbd_pkg::DEPTH;
					else
						idx = (back_idx + cbd_pkg::DEPTH - it.read_offset) % cbd_pkg::DEPTH;
					r.data_out = slots[idx];
				end
			end
			default: ;
			endcase
			r.entries_held = 8'(held);
			r.is_empty = (held == 0);
			r.is_full = (held == cbd_pkg::DEPTH);
			if (held > peak_held)
				peak_held = held;
			status_tally[r.status]++;
			owed.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH at result %0d, %s: got %0h, expected %0h",
				checked, what, got, want);
			mismatches++;
		endtask

		task check_result(cbd_pkg::out_item_t got);
			cbd_pkg::out_item_t want;
			if (owed.size() == 0) begin
				report("result with nothing owed", got.data_out, 0);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got.status !== want.status)
				report("status", got.status, want.status);
			if (got.data_out !== want.data_out)
				report("data_out", got.data_out, want.data_out);
			if (got.entries_held !== want.entries_held)
				report("entries_held", got.entries_held, want.entries_held);
			if (got.is_empty !== want.is_empty)
				report("is_empty", got.is_empty, want.is_empty);
			if (got.is_full !== want.is_full)
				report("is_full", got.is_full, want.is_full);
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	cbd_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	cbd_pkg::out_item_t out_item;

	deque_tracker tracker;
	int unsigned  accepted;
	bit           hold_request;

	circular_buffer_deque dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	// Mostly random payload, with the sign and all-ones corners turning up often.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(19, 0))
		0: return 32'h7fff_ffff;
		1: return 32'h8000_0000;
		2: return 32'h0000_0000;
		3: return 32'hffff_ffff;
		default: return $urandom();
		endcase
	endfunction

	function automatic cbd_pkg::in_item_t make_op(logic [2:0] mode, logic [31:0] value,
		logic [6:0] offset);
		cbd_pkg::in_item_t it;
		it.mode = mode;
		it.push_value = value;
		it.read_offset = offset;
		return it;
	endfunction

	// Random operation steered by the current trend. Reads mostly land on live
	// entries; the rest take any offset so out-of-range reads keep turning up.
	function automatic cbd_pkg::in_item_t next_op(int trend);
		cbd_pkg::in_item_t it;
		int roll;
		int push_pct;
		int pop_pct;
		push_pct = (trend == TREND_FILL) ? 75 : (trend == TREND_DRAIN) ? 10 : 38;
		pop_pct = (trend == TREND_FILL) ? 10 : (trend == TREND_DRAIN) ? 75 : 32;
		it.push_value = pick_value();
		it.read_offset = 7'($urandom_range(127, 0));
		roll = $urandom_range(99, 0);
		if (roll < 3) begin
			it.mode = $urandom_range(1, 0) ? MODE_SPARE_A : MODE_SPARE_B;
		end else if (roll < 3 + push_pct) begin
			it.mode = $urandom_range(1, 0) ? cbd_pkg::MODE_PUSH_FRONT
			                               : cbd_pkg::MODE_PUSH_BACK;
		end else if (roll < 3 + push_pct + pop_pct) begin
			it.mode = $urandom_range(1, 0) ? cbd_pkg::MODE_POP_FRONT
			                               : cbd_pkg::MODE_POP_BACK;
		end else begin
			it.mode = $urandom_range(1, 0) ? cbd_pkg::MODE_READ_FRONT
			                               : cbd_pkg::MODE_READ_BACK;
			if (tracker.held > 0 && $urandom_range(99, 0) < 85)
				it.read_offset = 7'($urandom_range(tracker.held - 1, 0));
		end
		return it;
	endfunction

	// Holds valid and payload until the block takes the item, then logs it.
	task automatic offer(input cbd_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_accepted(it);
		accepted++;
		if (accepted == HOLD_AT)
			hold_request = 1'b1;
	endtask

	// Receiver: checks every delivered item, then picks the next ready level.
	// The stall style is redrawn whenever its random run ends; once, on request, ready
	// is held low for a long stretch so the block backs up into its input.
	int  rx_style;
	int  rx_style_left;
	int  rx_hold_left;
	bit  rx_hold_used;
	int unsigned rx_cycle;

	initial begin
		rx_style = RX_OPEN;
		rx_style_left = 0;
		rx_hold_left = 0;
		rx_hold_used = 1'b0;
		rx_cycle = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(out_item);
		rx_cycle++;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request && !rx_hold_used) begin
			rx_hold_used = 1'b1;
			rx_hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_style_left == 0) begin
				rx_style = $urandom_range(RX_SPARSE, RX_OPEN);
				rx_style_left = $urandom_range(80, 16);
			end
			rx_style_left--;
			case (rx_style)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(1, 0));
			RX_EVERY4TH: out_ready <= (rx_cycle % 4 != 0);
			default:     out_ready <= ($urandom_range(3, 0) == 0);
			endcase
		end
	end

	// Sender and run control.
	initial begin
		cbd_pkg::in_item_t plan[$];
		cbd_pkg::in_item_t it;
		int total;
		int burst_left;
		int trend;
		int trend_left;
		int waited;

		tracker = new();
		accepted = 0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;

		// directed opening: empty-deque rejections, spare modes, extremes of
		// value, both ends, reads at and past the count, pop to empty and a
		// fresh push after the deque has been emptied
		plan.push_back(make_op(cbd_pkg::MODE_READ_FRONT, pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_READ_BACK,  pick_value(), 7'd127));
		plan.push_back(make_op(cbd_pkg::MODE_POP_FRONT,  pick_value(), 7'd127));
		plan.push_back(make_op(cbd_pkg::MODE_POP_BACK,   pick_value(), 7'd0));
		plan.push_back(make_op(MODE_SPARE_A,             pick_value(), 7'd5));
		plan.push_back(make_op(cbd_pkg::MODE_PUSH_BACK,  32'h7fff_ffff, 7'd127));
		plan.push_back(make_op(cbd_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_PUSH_BACK,  32'hffff_ffff, 7'd85));
		plan.push_back(make_op(cbd_pkg::MODE_PUSH_FRONT, 32'h0000_0000, 7'd42));
		plan.push_back(make_op(cbd_pkg::MODE_READ_FRONT, pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_READ_BACK,  pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_READ_FRONT, pick_value(), 7'd3));
		plan.push_back(make_op(cbd_pkg::MODE_READ_BACK,  pick_value(), 7'd3));
		plan.push_back(make_op(cbd_pkg::MODE_READ_FRONT, pick_value(), 7'd4));
		plan.push_back(make_op(cbd_pkg::MODE_READ_BACK,  pick_value(), 7'd127));
		plan.push_back(make_op(MODE_SPARE_B,             pick_value(), 7'd1));
		plan.push_back(make_op(cbd_pkg::MODE_POP_BACK,   pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_POP_FRONT,  pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_POP_FRONT,  pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_POP_BACK,   pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_POP_BACK,   pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_PUSH_FRONT, 32'h0000_0001, 7'd127));
		plan.push_back(make_op(cbd_pkg::MODE_READ_BACK,  pick_value(), 7'd0));
		plan.push_back(make_op(cbd_pkg::MODE_POP_FRONT,  pick_value(), 7'd0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = plan.size() + RANDOM_ITEMS;
		burst_left = 0;
		trend = TREND_FILL;
		trend_left = $urandom_range(320, 200);
		for (int n = 0; n < total; n++) begin
			// bursts of back-to-back items separated by short idle gaps;
			// now and then a long unbroken run
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(posedge clk);
				burst_left = ($urandom_range(9, 0) == 0) ?
					$urandom_range(200, 80) : $urandom_range(24, 1);
			end
			burst_left--;
			if (n < plan.size()) begin
				it = plan[n];
			end else begin
				// fill to full, drain to empty, churn in between, in rotation
				if (trend_left == 0) begin
					trend = (trend + 1) % 3;
					trend_left = (trend == TREND_CHURN) ?
						$urandom_range(150, 60) : $urandom_range(320, 200);
				end
				trend_left--;
				it = next_op(trend);
			end
			offer(it);
		end
		in_valid <= 1'b0;

		waited = 0;
		while (tracker.owed.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// keep clocking so any stray extra result shows up
		repeat (8) @(posedge clk);
		if (tracker.owed.size() != 0)
			tracker.report("results never delivered", tracker.owed.size(), 0);

		$display("%0d items accepted, %0d results checked: %0d ok, %0d push on full,",
			accepted, tracker.checked, tracker.status_tally[cbd_pkg::ST_OK],
			tracker.status_tally[cbd_pkg::ST_FULL]);
		$display("%0d pop on empty, %0d reads past the count; peak fill %0d of %0d, full %0d times",
			tracker.status_tally[cbd_pkg::ST_EMPTY], tracker.status_tally[cbd_pkg::ST_RANGE],
			tracker.peak_held, cbd_pkg::DEPTH, tracker.full_hits);
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
